// ===== hdl/dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and ring index helpers for the double-ended queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_DUMP       = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_POP_REAR   = 3'd4;
    localparam logic [2:0] MODE_EMPTY_TEST = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } t_dq_in;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               is_empty;
        logic               last;
    } t_dq_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DUMP
    } t_dq_state;

    typedef enum logic [1:0] {
        RSEL_FRONT,
        RSEL_REAR,
        RSEL_DUMP
    } t_dq_rsel;

    typedef struct packed {
        logic       ld_cmd;
        logic       rd_en;
        t_dq_rsel   rd_sel;
        logic       idx_inc;
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic       emit;
        logic       use_rd;
        logic [1:0] status;
        logic       last;
    } t_dq_ctl;

    typedef struct packed {
        logic [2:0] mode;
        logic       empty;
        logic       full;
        logic       dump_last;
    } t_dq_sts;

    function automatic logic [AW-1:0] dq_wrap_add(input logic [AW-1:0] base,
                                                  input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(off);
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] dq_wrap_dec(input logic [AW-1:0] base);
        logic [AW-1:0] r;
        if (base == '0) begin
            r = AW'(DEPTH - 1);
        end else begin
            r = base - AW'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Operation sequencer: decodes the held command and steps the datapath.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire dq_pkg::t_dq_sts i_sts,
    output dq_pkg::t_dq_ctl      o_ctl
);

    dq_pkg::t_dq_state r_state;
    dq_pkg::t_dq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != dq_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            dq_pkg::S_IDLE: begin
                if (start) begin
                    o_ctl.ld_cmd = 1'b1;
                    n_state      = dq_pkg::S_EXEC;
                end
            end
            dq_pkg::S_EXEC: begin
                n_state = dq_pkg::S_IDLE;
                unique case (i_sts.mode) inside
                    dq_pkg::MODE_DUMP: begin
                        if (i_sts.empty) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = dq_pkg::ST_EMPTY;
                            o_ctl.last   = 1'b1;
                        end else begin
                            o_ctl.rd_en   = 1'b1;
                            o_ctl.rd_sel  = dq_pkg::RSEL_DUMP;
                            o_ctl.idx_inc = 1'b1;
                            n_state       = dq_pkg::S_DUMP;
                        end
                    end
                    dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_REAR: begin
                        o_ctl.emit = 1'b1;
                        o_ctl.last = 1'b1;
                        if (i_sts.full) begin
                            o_ctl.status = dq_pkg::ST_FULL;
                        end else begin
                            o_ctl.status     = dq_pkg::ST_OK;
                            o_ctl.push_front = (i_sts.mode == dq_pkg::MODE_PUSH_FRONT);
                            o_ctl.push_rear  = (i_sts.mode == dq_pkg::MODE_PUSH_REAR);
                        end
                    end
                    dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_REAR: begin
                        if (i_sts.empty) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = dq_pkg::ST_EMPTY;
                            o_ctl.last   = 1'b1;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = (i_sts.mode == dq_pkg::MODE_POP_FRONT) ?
                                           dq_pkg::RSEL_FRONT : dq_pkg::RSEL_REAR;
                            n_state      = dq_pkg::S_POP;
                        end
                    end
                    dq_pkg::MODE_EMPTY_TEST: begin
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = i_sts.empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
                        o_ctl.last   = 1'b1;
                    end
                    default: begin
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = dq_pkg::ST_OK;
                        o_ctl.last   = 1'b1;
                    end
                endcase
            end
            dq_pkg::S_POP: begin
                o_ctl.emit      = 1'b1;
                o_ctl.use_rd    = 1'b1;
                o_ctl.status    = dq_pkg::ST_OK;
                o_ctl.last      = 1'b1;
                o_ctl.pop_front = (i_sts.mode == dq_pkg::MODE_POP_FRONT);
                o_ctl.pop_rear  = (i_sts.mode != dq_pkg::MODE_POP_FRONT);
                n_state         = dq_pkg::S_IDLE;
            end
            dq_pkg::S_DUMP: begin
                o_ctl.emit    = 1'b1;
                o_ctl.use_rd  = 1'b1;
                o_ctl.status  = dq_pkg::ST_OK;
                o_ctl.last    = i_sts.dump_last;
                o_ctl.rd_en   = 1'b1;
                o_ctl.rd_sel  = dq_pkg::RSEL_DUMP;
                o_ctl.idx_inc = 1'b1;
                if (i_sts.dump_last) begin
                    n_state = dq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/dq_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, front pointer, occupancy count and result register.
// ----------------------------------------------------------------------------
module dq_dpath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dq_pkg::t_dq_in  i_cmd,
    input  wire dq_pkg::t_dq_ctl i_ctl,
    output dq_pkg::t_dq_sts      o_sts,
    output logic                 o_done,
    output dq_pkg::t_dq_out      o_result
);

    logic signed [31:0]    r_mem [dq_pkg::DEPTH];
    dq_pkg::t_dq_in        r_cmd;
    logic [dq_pkg::AW-1:0] r_front;
    logic [dq_pkg::AW-1:0] n_front;
    logic [dq_pkg::CW-1:0] r_count;
    logic [dq_pkg::CW-1:0] n_count;
    logic [dq_pkg::CW-1:0] r_idx;
    logic signed [31:0]    r_rd_data;
    logic                  r_done;
    dq_pkg::t_dq_out       r_out;
    logic [dq_pkg::AW-1:0] wr_addr;
    logic [dq_pkg::AW-1:0] rd_addr;
    logic                  wr_en;

    assign wr_en = i_ctl.push_front | i_ctl.push_rear;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        wr_addr = dq_pkg::dq_wrap_add(r_front, r_count);
        if (i_ctl.push_front) begin
            n_front = dq_pkg::dq_wrap_dec(r_front);
            wr_addr = n_front;
            n_count = r_count + dq_pkg::CW'(1);
        end else if (i_ctl.push_rear) begin
            n_count = r_count + dq_pkg::CW'(1);
        end else if (i_ctl.pop_front) begin
            n_front = dq_pkg::dq_wrap_add(r_front, dq_pkg::CW'(1));
            n_count = r_count - dq_pkg::CW'(1);
        end else if (i_ctl.pop_rear) begin
            n_count = r_count - dq_pkg::CW'(1);
        end
    end

    always_comb begin
        case (i_ctl.rd_sel)
            dq_pkg::RSEL_FRONT: rd_addr = r_front;
            dq_pkg::RSEL_REAR:  rd_addr = dq_pkg::dq_wrap_add(r_front,
                                                               r_count - dq_pkg::CW'(1));
            default:            rd_addr = dq_pkg::dq_wrap_add(r_front, r_idx);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_cmd.value;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_cmd) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.emit) begin
            r_out.data     <= i_ctl.use_rd ? r_rd_data : 32'sd0;
            r_out.status   <= i_ctl.status;
            r_out.is_empty <= (n_count == '0);
            r_out.last     <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= i_ctl.emit;
            if (i_ctl.ld_cmd) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + dq_pkg::CW'(1);
            end
        end
    end

    assign o_sts.mode      = r_cmd.mode;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == dq_pkg::CW'(dq_pkg::DEPTH));
    assign o_sts.dump_last = (r_idx == r_count);
    assign o_done          = r_done;
    assign o_result        = r_out;

endmodule
`default_nettype wire

// ===== hdl/double_ended_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit values held in a 16-entry ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_cmd (mode, value) and raise start; the command beat is taken on
//   the edge where start is high and busy is low. Modes: dump, push front,
//   push rear, pop front, pop rear, empty test.
//   Each result beat appears on o_result for one cycle with o_done high and
//   must be captured then; the receiver has no way to stall the block.
//   Push, empty test and refused ops emit one result beat from the execute
//   state. A pop reads the ring store into a read register in the execute
//   state and emits from the pop state. A dump of N elements gives N results,
//   one per cycle, last set on the final one. No new command beat is taken
//   until the sequencer is idle again.
//   The rate is set by the single registered read port of the ring store and
//   the one-command-at-a-time sequencer.
//   Reset (i_rst_n low, synchronous) empties the queue and returns the
//   sequencer to idle; ring contents are left as they are.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire dq_pkg::t_dq_in i_cmd,
    output logic                o_done,
    output dq_pkg::t_dq_out     o_result
);

    dq_pkg::t_dq_ctl ctl;
    dq_pkg::t_dq_sts sts;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    dq_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== tb/double_ended_queue_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Runs directed and random deque operations through the core. A shadow deque
// works out the result beats of each accepted command. Each result beat on
// o_result is checked field by field against the oldest beat still owed.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;

    import dq_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int         RANDOM_OPS   = 350;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         TAIL_CYCLES  = 40;

    typedef struct {
        t_dq_in cmd;
        int     gap;
        bit     drain;
    } t_op_slot;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_dq_in  i_cmd   = '0;
    logic    o_done;
    t_dq_out o_result;

    t_op_slot    op_backlog[$];
    t_dq_out     deque_results_due[$];
    int          gap_left = -1;

    logic signed [31:0] shadow_ring [DEPTH];
    int          shadow_front;
    int          shadow_held;

    int          cycle_count;
    int          mismatch_count;
    int          ops_taken;
    int          beats_checked;
    int          full_refusals;
    int          empty_reports;

    double_ended_queue_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t after %0d cycles", $time, cycle_count);
            $display("double_ended_queue_core_test NOT OK");
            $finish;
        end
    end

    task automatic queue_op(input logic [2:0] mode, input logic signed [31:0] value,
                            input int gap, input bit drain);
        t_op_slot slot;
        slot.cmd.mode  = mode;
        slot.cmd.value = value;
        slot.gap       = gap;
        slot.drain     = drain;
        op_backlog.push_back(slot);
    endtask

    // advance the shadow deque by one command and queue its result beats
    function automatic void deque_apply(input t_dq_in cmd);
        t_dq_out beat;
        int      k;
        beat      = '0;
        beat.last = 1'b1;
        case (cmd.mode)
            MODE_DUMP: begin
                if (shadow_held == 0) begin
                    beat.status   = ST_EMPTY;
                    beat.is_empty = 1'b1;
                    empty_reports++;
                    deque_results_due.push_back(beat);
                end else begin
                    for (k = 0; k < shadow_held; k++) begin
                        beat.data   = shadow_ring[(shadow_front + k) % DEPTH];
                        beat.status = ST_OK;
                        beat.last   = (k == shadow_held - 1);
                        deque_results_due.push_back(beat);
                    end
                end
                return;
            end
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (shadow_held >= DEPTH) begin
                    beat.status = ST_FULL;
                    full_refusals++;
                end else if (cmd.mode == MODE_PUSH_FRONT) begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_front] = cmd.value;
                    shadow_held++;
                end else begin
                    shadow_ring[(shadow_front + shadow_held) % DEPTH] = cmd.value;
                    shadow_held++;
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (shadow_held == 0) begin
                    beat.status = ST_EMPTY;
                    empty_reports++;
                end else if (cmd.mode == MODE_POP_FRONT) begin
                    beat.data    = shadow_ring[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_held--;
                end else begin
                    beat.data = shadow_ring[(shadow_front + shadow_held - 1) % DEPTH];
                    shadow_held--;
                end
            end
            MODE_EMPTY_TEST: begin
                beat.status = (shadow_held == 0) ? ST_EMPTY : ST_OK;
            end
            default: begin
                beat.status = ST_OK;
            end
        endcase
        beat.is_empty = (shadow_held == 0);
        deque_results_due.push_back(beat);
    endfunction

    // driver: present the next command beat once its gap has run out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cmd    <= '0;
            gap_left = -1;
        end else if (!start || !busy) begin
            if (op_backlog.size() == 0) begin
                start <= 1'b0;
            end else begin
                if (gap_left < 0) begin
                    gap_left = op_backlog[0].gap;
                end
                if (gap_left == 0 && (!op_backlog[0].drain ||
                                      (!start && deque_results_due.size() == 0))) begin
                    start    <= 1'b1;
                    i_cmd    <= op_backlog[0].cmd;
                    gap_left = -1;
                    void'(op_backlog.pop_front());
                end else begin
                    start <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // monitor: check result beats, then predict for the beat taken on this edge
    always @(posedge i_clk) begin
        t_dq_out want;
        if (!i_rst_n) begin
            shadow_front = 0;
            shadow_held  = 0;
        end else begin
            if (o_done !== 1'b0) begin
                beats_checked++;
                if (deque_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat data=%h status=%0d empty=%b last=%b",
                             $time, o_result.data, o_result.status, o_result.is_empty,
                             o_result.last);
                end else begin
                    want = deque_results_due.pop_front();
                    if (o_result.data !== want.data || o_result.status !== want.status ||
                        o_result.is_empty !== want.is_empty || o_result.last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: mismatch expected data=%h status=%0d empty=%b last=%b",
                                 $time, want.data, want.status, want.is_empty, want.last);
                        $display("%0t:          actual   data=%h status=%0d empty=%b last=%b",
                                 $time, o_result.data, o_result.status, o_result.is_empty,
                                 o_result.last);
                    end
                end
            end
            if (start && busy === 1'b0) begin
                ops_taken++;
                deque_apply(i_cmd);
            end
        end
    end

    initial begin
        int                 k;
        int                 n;
        int                 burst_len;
        int                 roll;
        bit                 fill_bias;
        bit                 quiet;
        logic [2:0]         mode;
        logic signed [31:0] value;

        cycle_count    = 0;
        mismatch_count = 0;
        ops_taken      = 0;
        beats_checked  = 0;
        full_refusals  = 0;
        empty_reports  = 0;

        // empty queue corner cases
        queue_op(MODE_DUMP, 32'sh1234_5678, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_POP_FRONT, 32'sh7FFF_FFFF, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_POP_REAR, -32'sd1, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_EMPTY_TEST, 32'sh0, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_SPARE_A, 32'sh5A5A_5A5A, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_SPARE_B, 32'shA5A5_A5A5, $urandom_range(0, 6), 1'b0);
        // extreme values through both ends
        queue_op(MODE_PUSH_FRONT, 32'sh8000_0000, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_PUSH_REAR, 32'sh7FFF_FFFF, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_PUSH_FRONT, -32'sd1, 0, 1'b0);
        queue_op(MODE_PUSH_REAR, 32'sh0, 0, 1'b0);
        queue_op(MODE_DUMP, 32'sh0, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_EMPTY_TEST, 32'sh0, 0, 1'b0);
        queue_op(MODE_POP_FRONT, 32'sh0, 0, 1'b0);
        queue_op(MODE_POP_REAR, 32'sh0, $urandom_range(0, 6), 1'b0);
        // fill to full, then hit both refusals and dump the full ring
        for (k = 0; k < DEPTH - 2; k++) begin
            value = k[0] ? (32'sh5555_5555 ^ k) : (32'shAAAA_AAAA ^ k);
            queue_op(k[0] ? MODE_PUSH_REAR : MODE_PUSH_FRONT, value, 0, 1'b0);
        end
        queue_op(MODE_PUSH_FRONT, 32'sh1111_1111, $urandom_range(0, 6), 1'b0);
        queue_op(MODE_PUSH_REAR, 32'sh2222_2222, 0, 1'b0);
        queue_op(MODE_DUMP, 32'sh0, 0, 1'b0);
        queue_op(MODE_EMPTY_TEST, 32'sh0, 0, 1'b1);

        // random bursts that lean toward filling or draining the queue
        n = 0;
        while (n < RANDOM_OPS) begin
            burst_len = $urandom_range(1, 20);
            fill_bias = 1'($urandom_range(0, 1));
            quiet     = ($urandom_range(0, 2) == 0);
            for (k = 0; k < burst_len && n < RANDOM_OPS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    mode = MODE_DUMP;
                end else if (roll < 8) begin
                    mode = MODE_EMPTY_TEST;
                end else if (roll < 10) begin
                    mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
                end else if (($urandom_range(0, 99) < 80) == fill_bias) begin
                    mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
                end else begin
                    mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
                end
                case ($urandom_range(0, 9))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = 32'sh0;
                    3:       value = -32'sd1;
                    default: value = $urandom;
                endcase
                queue_op(mode, value, quiet ? 0 : $urandom_range(0, 6), (n % 60) == 59);
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || start || deque_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (deque_results_due.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d result beats never arrived", $time, deque_results_due.size());
        end
        $display("ran %0d commands and checked %0d result beats", ops_taken, beats_checked);
        $display("saw %0d refused pushes and %0d empty reports", full_refusals, empty_reports);
        if (mismatch_count == 0) begin
            $display("double_ended_queue_core_test OK");
        end else begin
            $display("double_ended_queue_core_test NOT OK");
        end
        $finish;
    end

endmodule
